// ===== hdl/jads_pkg.sv =====
package jads_pkg;

  localparam int unsigned SampleBits     = 12;
  localparam int unsigned FullScaleBits  = 12;
  localparam int unsigned RatioBits      = 8;
  localparam int unsigned CfgDataBits    = 12;
  localparam int unsigned SumBits        = 20;
  localparam int unsigned CountBits      = 9;
  localparam int unsigned OffsetBits     = 12;
  localparam int unsigned CalibSamples   = 16;
  localparam int unsigned FracBits       = 8;
  localparam int unsigned ScaledBits     = SampleBits + FracBits;
  localparam int unsigned UpperBits      = ScaledBits + 1;
  localparam int unsigned FactorBits     = RatioBits + 1;
  localparam int unsigned Num100Bits     = ScaledBits + 7;
  localparam int unsigned DvdBits        = Num100Bits + FracBits;
  localparam int unsigned StepBits       = $clog2(DvdBits);
  localparam int unsigned PctBits        = 16;
  localparam int unsigned InDataBits     = 16;
  localparam int unsigned InUserBits     = 2;
  localparam int unsigned OutUserBits    = 3;

  localparam logic [PctBits-1:0]       PctFull        = 16'd25600;
  localparam logic [FullScaleBits-1:0] FullScaleReset = 12'd4095;
  localparam logic [RatioBits-1:0]     RatioReset     = 8'd26;

  typedef enum logic [0:0] {
    CFG_FULL_SCALE     = 1'b0,
    CFG_DEADZONE_RATIO = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    ACT_CALIB   = 1'b0,
    ACT_MEASURE = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_CLASS,
    ST_DIV,
    ST_SAT,
    ST_FINISH
  } state_e;

endpackage

// ===== hdl/joystick_axis_deadzone_scaler_core.sv =====
// Joystick axis center calibration and deadzone scaler. Each input beat carries one ADC
// sample; a calibration beat adds to the running center estimate and, on every sixteenth
// one, loads the center offset with the truncated mean and flags calib_done. A measure
// beat is compared with the deadzone thresholds offset*(1-r) and offset*(1+r) and gives
// a signed Q8 percent (saturating at plus or minus 100) or zero inside the deadzone.
// Every input beat produces exactly one output beat. A calibration beat goes straight
// to the finish state; a measure beat outside the deadzone passes the product, classify,
// divide and saturate states, the restoring divider retiring one quotient bit per cycle
// over a 35 bit dividend. A beat inside the deadzone, or with a zero or negative
// denominator, skips the divider. One beat is in flight at a time, but a finished result
// may wait in the output register while the next beat is accepted. Configuration writes
// are taken at any time and must only be issued while the block is idle.
module joystick_axis_deadzone_scaler_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0: sample (12 bits), zero padding.
  input  logic [jads_pkg::InDataBits-1:0]      s_axis_tdata,
  // Fields from bit 0: action, axis.
  input  logic [jads_pkg::InUserBits-1:0]      s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // Fields from bit 0: percent (16 bits, signed).
  output logic [jads_pkg::PctBits-1:0]         m_axis_tdata,
  // Fields from bit 0: axis_out, in_deadzone, calib_done.
  output logic [jads_pkg::OutUserBits-1:0]     m_axis_tuser,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [0:0]                           cfg_index_i,
  input  logic [jads_pkg::CfgDataBits-1:0]     cfg_data_i
);

  jads_pkg::state_e state_q, state_d;

  logic [jads_pkg::FullScaleBits-1:0] full_scale_q;
  logic [jads_pkg::RatioBits-1:0]     ratio_q;
  logic [jads_pkg::SumBits-1:0]       cal_sum_q;
  logic [jads_pkg::CountBits-1:0]     cal_count_q;
  logic [jads_pkg::OffsetBits-1:0]    offset_q;

  logic [jads_pkg::SampleBits-1:0]    sample_q;
  logic                               axis_q;
  logic [jads_pkg::UpperBits-1:0]     upper_q;
  logic [jads_pkg::ScaledBits-1:0]    lower_q;
  logic [jads_pkg::ScaledBits-1:0]    den_q;
  logic [jads_pkg::ScaledBits-1:0]    rem_q;
  logic [jads_pkg::DvdBits-1:0]       dvd_q;
  logic [jads_pkg::StepBits-1:0]      cnt_q;
  logic                               neg_q;

  logic [jads_pkg::PctBits-1:0]       res_pct_q;
  logic                               res_dz_q;
  logic                               res_done_q;

  logic                               m_valid_q;
  logic [jads_pkg::PctBits-1:0]       m_pct_q;
  logic                               m_axis_q;
  logic                               m_dz_q;
  logic                               m_done_q;

  logic in_accept, out_free, out_load, div_load, div_last;

  logic [jads_pkg::SampleBits-1:0] in_sample;
  logic                            in_is_calib;
  logic [jads_pkg::SumBits-1:0]    sum_next;
  logic [jads_pkg::CountBits-1:0]  count_next;
  logic [jads_pkg::SumBits-1:0]    mean_full;
  logic                            batch_end;

  logic [jads_pkg::FactorBits-1:0] fac_up, fac_lo;
  logic [jads_pkg::UpperBits-1:0]  prod_up, prod_lo;

  logic [jads_pkg::ScaledBits-1:0] s_scaled, fs_scaled, den_up, num_w, den_w;
  logic                            above, below, in_dz, den_ok;
  logic [jads_pkg::Num100Bits-1:0] num100;
  logic [jads_pkg::DvdBits-1:0]    dvd_load;

  logic [jads_pkg::UpperBits-1:0]  trial, trial_diff;
  logic                            trial_ge;
  logic [jads_pkg::PctBits-1:0]    sat_mag, pct_final;

  assign in_sample   = s_axis_tdata[jads_pkg::SampleBits-1:0];
  assign in_is_calib = (s_axis_tuser[0] == jads_pkg::ACT_CALIB);
  assign in_accept   = s_axis_tvalid && s_axis_tready;
  assign out_free    = !m_valid_q || m_axis_tready;
  assign cfg_ready_o = 1'b1;

  assign sum_next   = cal_sum_q + jads_pkg::SumBits'(in_sample);
  assign count_next = cal_count_q + jads_pkg::CountBits'(1);
  assign batch_end  = count_next >= jads_pkg::CountBits'(jads_pkg::CalibSamples);
  assign mean_full  = sum_next / jads_pkg::SumBits'(jads_pkg::CalibSamples);

  assign fac_up  = {1'b1, ratio_q};
  assign fac_lo  = {1'b1, {jads_pkg::RatioBits{1'b0}}} - jads_pkg::FactorBits'(ratio_q);
  assign prod_up = jads_pkg::UpperBits'(offset_q) * jads_pkg::UpperBits'(fac_up);
  assign prod_lo = jads_pkg::UpperBits'(offset_q) * jads_pkg::UpperBits'(fac_lo);

  always_comb begin
    s_scaled  = {sample_q, {jads_pkg::FracBits{1'b0}}};
    fs_scaled = {full_scale_q, {jads_pkg::FracBits{1'b0}}};
    above     = {1'b0, s_scaled} > upper_q;
    below     = s_scaled < lower_q;
    in_dz     = !above && !below;
    den_up    = fs_scaled - upper_q[jads_pkg::ScaledBits-1:0];
    if (above) begin
      num_w  = s_scaled - upper_q[jads_pkg::ScaledBits-1:0];
      den_w  = den_up;
      den_ok = {1'b0, fs_scaled} > upper_q;
    end else begin
      num_w  = lower_q - s_scaled;
      den_w  = lower_q;
      den_ok = lower_q != '0;
    end
    num100   = {1'b0, num_w, 6'b0} + {2'b0, num_w, 5'b0} + {5'b0, num_w, 2'b0};
    dvd_load = {num100, {jads_pkg::FracBits{1'b0}}};
  end

  assign trial      = {rem_q, dvd_q[jads_pkg::DvdBits-1]};
  assign trial_diff = trial - {1'b0, den_q};
  assign trial_ge   = trial >= {1'b0, den_q};
  assign div_last   = cnt_q == '0;

  always_comb begin
    if (dvd_q > jads_pkg::DvdBits'(jads_pkg::PctFull)) begin
      sat_mag = jads_pkg::PctFull;
    end else begin
      sat_mag = dvd_q[jads_pkg::PctBits-1:0];
    end
    pct_final = neg_q ? (~sat_mag + jads_pkg::PctBits'(1)) : sat_mag;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jads_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = in_is_calib ? jads_pkg::ST_FINISH : jads_pkg::ST_PROD;
        end
      end
      jads_pkg::ST_PROD:  state_d = jads_pkg::ST_CLASS;
      jads_pkg::ST_CLASS: begin
        state_d = (in_dz || !den_ok) ? jads_pkg::ST_FINISH : jads_pkg::ST_DIV;
      end
      jads_pkg::ST_DIV: begin
        if (div_last) begin
          state_d = jads_pkg::ST_SAT;
        end
      end
      jads_pkg::ST_SAT:   state_d = jads_pkg::ST_FINISH;
      jads_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = jads_pkg::ST_IDLE;
        end
      end
      default: state_d = jads_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    div_load      = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      jads_pkg::ST_IDLE:   s_axis_tready = 1'b1;
      jads_pkg::ST_CLASS:  div_load = !in_dz && den_ok;
      jads_pkg::ST_FINISH: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= jads_pkg::ST_IDLE;
      full_scale_q <= jads_pkg::FullScaleReset;
      ratio_q      <= jads_pkg::RatioReset;
      cal_sum_q    <= '0;
      cal_count_q  <= '0;
      offset_q     <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (jads_pkg::cfg_idx_e'(cfg_index_i))
          jads_pkg::CFG_FULL_SCALE:     full_scale_q <= cfg_data_i;
          jads_pkg::CFG_DEADZONE_RATIO: ratio_q <= cfg_data_i[jads_pkg::RatioBits-1:0];
          default: ;
        endcase
      end
      if (in_accept && in_is_calib) begin
        if (batch_end) begin
          offset_q    <= mean_full[jads_pkg::OffsetBits-1:0];
          cal_sum_q   <= '0;
          cal_count_q <= '0;
        end else begin
          cal_sum_q   <= sum_next;
          cal_count_q <= count_next;
        end
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q   <= in_sample;
      axis_q     <= s_axis_tuser[1];
      res_pct_q  <= '0;
      res_dz_q   <= 1'b0;
      res_done_q <= in_is_calib && batch_end;
    end
    if (state_q == jads_pkg::ST_PROD) begin
      upper_q <= prod_up;
      lower_q <= prod_lo[jads_pkg::ScaledBits-1:0];
    end
    if (state_q == jads_pkg::ST_CLASS) begin
      res_dz_q <= in_dz;
      neg_q    <= below;
      if (in_dz) begin
        res_pct_q <= '0;
      end else begin
        res_pct_q <= above ? jads_pkg::PctFull : (~jads_pkg::PctFull + jads_pkg::PctBits'(1));
      end
    end
    if (div_load) begin
      dvd_q <= dvd_load;
      den_q <= den_w;
      rem_q <= '0;
      cnt_q <= jads_pkg::StepBits'(jads_pkg::DvdBits - 1);
    end else if (state_q == jads_pkg::ST_DIV) begin
      dvd_q <= {dvd_q[jads_pkg::DvdBits-2:0], trial_ge};
      rem_q <= trial_ge ? trial_diff[jads_pkg::ScaledBits-1:0]
                        : trial[jads_pkg::ScaledBits-1:0];
      cnt_q <= cnt_q - jads_pkg::StepBits'(1);
    end
    if (state_q == jads_pkg::ST_SAT) begin
      res_pct_q <= pct_final;
    end
    if (out_load) begin
      m_pct_q  <= res_pct_q;
      m_axis_q <= axis_q;
      m_dz_q   <= res_dz_q;
      m_done_q <= res_done_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_pct_q;
  assign m_axis_tuser  = {m_done_q, m_dz_q, m_axis_q};

`ifndef SYNTH
  a_div_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jads_pkg::ST_DIV) |-> (den_q != '0))
    else $error("divider running with a zero denominator");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> ($signed(m_pct_q) <= $signed(jads_pkg::PctFull)
                   && $signed(m_pct_q) >= -$signed(jads_pkg::PctFull)))
    else $error("percent outside of the saturation range");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_dz_q) |-> (m_pct_q == '0 && !m_done_q))
    else $error("deadzone result with nonzero percent or calibration flag");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_count_q < jads_pkg::CountBits'(jads_pkg::CalibSamples))
    else $error("calibration count passed the batch size");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == jads_pkg::ST_PROD || state_q == jads_pkg::ST_FINISH))
    else $error("accepted beat did not start processing");
`endif

endmodule
